>>> design/mahd_pkg.sv
// Shared types, codes and lookup tables of the MPEG audio header decoder.
package mahd_pkg;

  // Result codes, in the order the checks are applied
  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_SYNC  = 3'd1,
    ERR_LAYER = 3'd2,
    ERR_RATE  = 3'd3,
    ERR_FREE  = 3'd4
  } err_code_t;

  localparam logic [31:0] SYNC_MASK        = 32'hffe0_0000;
  localparam logic [31:0] BAD_PATTERN_MASK = 32'h0000_fc00;

  // Layer codes as they appear in bits 18..17
  localparam logic [1:0] LCODE_NONE = 2'd0;
  localparam logic [1:0] LCODE_L3   = 2'd1;
  localparam logic [1:0] LCODE_L1   = 2'd3;

  localparam logic [17:0] L1_FACTOR  = 18'd12000;
  localparam logic [17:0] L23_FACTOR = 18'd144000;
  localparam logic [15:0] KBPS_TO_BYTES = 16'd125;

  localparam int NUM_W   = 26;  // frame size numerator
  localparam int DIV_W   = 16;  // divisor, fs or 2*fs
  localparam int RECIP_W = 14;  // floor(2^NUM_W / fs)
  localparam int QUO_W   = 14;  // first quotient estimate
  localparam int PROD_W  = NUM_W + RECIP_W;
  localparam int REM_W   = QUO_W + DIV_W;

  // Bitrate in kbit/s by [lsf][layer-1][bitrate index]
  localparam logic [8:0] KBPS_TBL [2][3][16] = '{
    '{ '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
         9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
       '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
       '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
         9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0} },
    '{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0} }
  };

  // Side information that rides along with the divide
  typedef struct packed {
    err_code_t   err;
    logic [1:0]  layer;
    logic        lsf;
    logic [1:0]  nch;
    logic [15:0] bitrate;
    logic [15:0] fs;
    logic        pad;
    logic        is_l1;
  } hdr_info_t;

  function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] lcode,
                                             input logic [3:0] bidx);
    logic [1:0] lidx;
    lidx = 2'd3 - lcode;
    if (lcode == LCODE_NONE) begin
      return 9'd0;
    end
    return KBPS_TBL[lsf][lidx][bidx];
  endfunction

  function automatic logic [15:0] rate_lookup(input logic [3:0] sf);
    case (sf)
      4'd0: return 16'd44100;
      4'd1: return 16'd48000;
      4'd2: return 16'd32000;
      4'd3: return 16'd22050;
      4'd4: return 16'd24000;
      4'd5: return 16'd16000;
      4'd6: return 16'd11025;
      4'd7: return 16'd12000;
      4'd8: return 16'd8000;
      default: return 16'd0;
    endcase
  endfunction

  // floor(2^26 / fs); halving it gives floor(2^26 / (2*fs))
  function automatic logic [RECIP_W-1:0] recip_lookup(input logic [3:0] sf);
    case (sf)
      4'd0: return 14'd1521;
      4'd1: return 14'd1398;
      4'd2: return 14'd2097;
      4'd3: return 14'd3043;
      4'd4: return 14'd2796;
      4'd5: return 14'd4194;
      4'd6: return 14'd6086;
      4'd7: return 14'd5592;
      4'd8: return 14'd8388;
      default: return 14'd0;
    endcase
  endfunction

endpackage

>>> design/mahd_decode.sv
// First stage: field decode, error checks, table lookups and numerator product.
module mahd_decode import mahd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [31:0]          header_word,
  output logic                 s1_valid,
  output logic [NUM_W-1:0]     s1_num,
  output logic [DIV_W-1:0]     s1_div,
  output logic [RECIP_W-1:0]   s1_recip,
  output hdr_info_t            s1_info
);

  logic [1:0]          lcode;
  logic                lsf;
  logic                ext25;
  logic [1:0]          rate_field;
  logic [3:0]          sf;
  logic [3:0]          bidx;
  logic [8:0]          kbps;
  logic [15:0]         fs;
  logic [RECIP_W-1:0]  recip;
  logic                l3_lsf;
  logic [26:0]         num_full;
  hdr_info_t           info;

  // Split the header word into its fields
  always_comb begin
    lcode      = header_word[18:17];
    ext25      = ~header_word[20];
    lsf        = header_word[20] ? ~header_word[19] : 1'b1;
    rate_field = header_word[11:10];
    bidx       = header_word[15:12];
    if (ext25) begin
      sf = 4'd6 + {2'b00, rate_field};
    end else begin
      sf = {2'b00, rate_field} + (lsf ? 4'd3 : 4'd0);
    end
    kbps   = kbps_lookup(lsf, lcode, bidx);
    fs     = rate_lookup(sf);
    recip  = recip_lookup(sf);
    l3_lsf = lsf && (lcode == LCODE_L3);
  end

  // Check in priority order and collect the side information
  always_comb begin
    info = '0;
    if ((header_word & SYNC_MASK) != SYNC_MASK ||
        (header_word & BAD_PATTERN_MASK) == BAD_PATTERN_MASK) begin
      info.err = ERR_SYNC;
    end else if (lcode == LCODE_NONE) begin
      info.err = ERR_LAYER;
    end else if (sf > 4'd8) begin
      info.err = ERR_RATE;
    end else if (bidx == 4'd0) begin
      info.err = ERR_FREE;
    end else begin
      info.err = ERR_NONE;
    end
    info.layer   = 2'd0 - lcode;
    info.lsf     = lsf;
    info.nch     = (header_word[7:6] == 2'b11) ? 2'd1 : 2'd2;
    info.bitrate = {7'b0, kbps} * KBPS_TO_BYTES;
    info.fs      = fs;
    info.pad     = header_word[9];
    info.is_l1   = (lcode == LCODE_L1);
  end

  // Numerator of the frame size division
  assign num_full = {18'b0, kbps} * {9'b0, (info.is_l1 ? L1_FACTOR : L23_FACTOR)};

  // Register the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_num   <= num_full[NUM_W-1:0];
      s1_div   <= l3_lsf ? {fs[DIV_W-2:0], 1'b0} : fs;
      s1_recip <= l3_lsf ? (recip >> 1) : recip;
      s1_info  <= info;
    end
  end

endmodule

>>> design/mahd_divide.sv
// Reciprocal divide: estimate stage, back-multiply stage, one-step correction.
module mahd_divide import mahd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 s1_valid,
  input  logic [NUM_W-1:0]     s1_num,
  input  logic [DIV_W-1:0]     s1_div,
  input  logic [RECIP_W-1:0]   s1_recip,
  input  hdr_info_t            s1_info,
  output logic                 q_valid,
  output logic [QUO_W-1:0]     quotient,
  output hdr_info_t            q_info
);

  logic [PROD_W-1:0]   est_prod;
  logic                s2_valid;
  logic [QUO_W-1:0]    s2_q0;
  logic [NUM_W-1:0]    s2_num;
  logic [DIV_W-1:0]    s2_div;
  hdr_info_t           s2_info;
  logic [REM_W-1:0]    back_prod;
  logic                s3_valid;
  logic [QUO_W-1:0]    s3_q0;
  logic [NUM_W-1:0]    s3_num;
  logic [DIV_W-1:0]    s3_div;
  logic [REM_W-1:0]    s3_back;
  hdr_info_t           s3_info;
  logic [REM_W-1:0]    rem;

  // Estimate: floor(num * recip / 2^26) is the quotient or one short of it
  assign est_prod = {{RECIP_W{1'b0}}, s1_num} * {{NUM_W{1'b0}}, s1_recip};

  // Back-multiply the estimate
  assign back_prod = {{DIV_W{1'b0}}, s2_q0} * {{QUO_W{1'b0}}, s2_div};

  // Correct the estimate by one when the remainder reaches the divisor
  assign rem      = {{(REM_W-NUM_W){1'b0}}, s3_num} - s3_back;
  assign quotient = (rem >= {{QUO_W{1'b0}}, s3_div}) ? s3_q0 + 1'b1 : s3_q0;
  assign q_valid  = s3_valid;
  assign q_info   = s3_info;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      s2_q0   <= est_prod[PROD_W-1:NUM_W];
      s2_num  <= s1_num;
      s2_div  <= s1_div;
      s2_info <= s1_info;
      s3_q0   <= s2_q0;
      s3_num  <= s2_num;
      s3_div  <= s2_div;
      s3_back <= back_prod;
      s3_info <= s2_info;
    end
  end

endmodule

>>> design/mpeg_audio_header_decoder_unit.sv
// Top level of the MPEG audio frame header decoder: pipeline and output register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready  | header_word
//  result  | out       | out_valid/out_ready  | header_ok, error_code, frame_bytes, layer,
//          |           |                      | low_rate_flag, channel_count,
//          |           |                      | bitrate_bytes, sample_rate_hz
//
// One header word per cycle unless a held result stalls the pipeline.
// Each result is registered in the decode, estimate, back-multiply and output stages.
// Synchronous reset clears all valid bits; payload registers are not reset.
// A held result stalls the whole pipeline in place; nothing is dropped or repeated.
module mpeg_audio_header_decoder_unit import mahd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] header_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        header_ok,
  output logic [2:0]  error_code,
  output logic [11:0] frame_bytes,
  output logic [1:0]  layer,
  output logic        low_rate_flag,
  output logic [1:0]  channel_count,
  output logic [15:0] bitrate_bytes,
  output logic [15:0] sample_rate_hz
);

  logic                adv;
  logic                s1_valid;
  logic [NUM_W-1:0]    s1_num;
  logic [DIV_W-1:0]    s1_div;
  logic [RECIP_W-1:0]  s1_recip;
  hdr_info_t           s1_info;
  logic                q_valid;
  logic [QUO_W-1:0]    quotient;
  hdr_info_t           q_info;
  logic [QUO_W-1:0]    padded;
  logic [11:0]         size;
  logic                ok;

  // Move every stage whenever the output register can take a beat
  assign adv      = ~out_valid | out_ready;
  assign in_ready = adv;

  mahd_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .en          (adv),
    .in_valid    (in_valid),
    .header_word (header_word),
    .s1_valid    (s1_valid),
    .s1_num      (s1_num),
    .s1_div      (s1_div),
    .s1_recip    (s1_recip),
    .s1_info     (s1_info)
  );

  mahd_divide u_divide (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .s1_valid (s1_valid),
    .s1_num   (s1_num),
    .s1_div   (s1_div),
    .s1_recip (s1_recip),
    .s1_info  (s1_info),
    .q_valid  (q_valid),
    .quotient (quotient),
    .q_info   (q_info)
  );

  // Add padding; layer 1 counts four-byte slots
  assign padded = quotient + {{(QUO_W-1){1'b0}}, q_info.pad};
  assign size   = q_info.is_l1 ? {padded[9:0], 2'b00} : padded[11:0];
  assign ok     = (q_info.err == ERR_NONE);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= q_valid;
    end
  end

  // Zero every field but the code on a rejected header
  always_ff @(posedge clk) begin
    if (adv) begin
      header_ok      <= ok;
      error_code     <= q_info.err;
      frame_bytes    <= ok ? size : 12'd0;
      layer          <= ok ? q_info.layer : 2'd0;
      low_rate_flag  <= ok & q_info.lsf;
      channel_count  <= ok ? q_info.nch : 2'd0;
      bitrate_bytes  <= ok ? q_info.bitrate : 16'd0;
      sample_rate_hz <= ok ? q_info.fs : 16'd0;
    end
  end

  // A good header always reports the ok code and a nonzero layer, channel count and sample rate
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (header_ok == (error_code == ERR_NONE)))
    else $error("header_ok disagrees with error_code");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && header_ok |-> layer != 2'd0 && channel_count != 2'd0 &&
                               sample_rate_hz != 16'd0)
    else $error("accepted header with empty fields");

  // A rejected header carries nothing but its code
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !header_ok |-> frame_bytes == 12'd0 && bitrate_bytes == 16'd0 &&
                                layer == 2'd0 && !low_rate_flag)
    else $error("rejected header carries field data");

  // A beat taken at the input shows up in the first stage next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_ready |=> s1_valid == $past(in_valid))
    else $error("first stage valid lost or invented");

  // The divide stages hold while the output is stalled
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(q_valid) && $stable(quotient))
    else $error("divide pipeline moved during stall");

endmodule
